[sv/depth_gradient_hole_fill_defines.svh]
// Assertion macros for the depth gradient hole fill block.
`ifndef DEPTH_GRADIENT_HOLE_FILL_DEFINES_SVH
`define DEPTH_GRADIENT_HOLE_FILL_DEFINES_SVH
`ifndef SYNTHESIS
`define DGHF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define DGHF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define DGHF_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define DGHF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[sv/dghf_pkg.sv]
// Shared types and constants for the depth gradient hole fill block.
package dghf_pkg;
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_RUN   = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    localparam logic [1:0] REG_HEIGHT = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_LIMIT  = 2'd2;

    localparam int CFG_BITS = 10;
    localparam logic [9:0] DEFAULT_PASS_LIMIT = 10'd1000;

    localparam logic [3:0] M_LEFT  = 4'b0001;
    localparam logic [3:0] M_RIGHT = 4'b0010;
    localparam logic [3:0] M_UP    = 4'b0100;
    localparam logic [3:0] M_DOWN  = 4'b1000;
endpackage

[sv/dghf_ram.sv]
// Generic single-port-write, single-read synchronous RAM with registered read.
module dghf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[sv/dghf_div.sv]
// Iterative unsigned divider by a 4-bit divisor (2, 4, 6 or 8 in this design): one quotient bit per cycle.
module dghf_div #(
    parameter int NUM_BITS = 36
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [NUM_BITS-1:0] dividend,
    input  logic [3:0]          divisor,
    output logic                done,
    output logic [NUM_BITS-1:0] quotient
);
    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] q_reg;
    logic [NUM_BITS-1:0] num_reg;
    logic [4:0]          rem_reg;
    logic [3:0]          dv_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [4:0]          trial;

    assign trial = {rem_reg[3:0], num_reg[NUM_BITS-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(NUM_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            rem_reg <= '0;
            dv_reg  <= divisor;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NUM_BITS-2:0], 1'b0};
            if (trial >= {1'b0, dv_reg})
            begin
                rem_reg <= trial - {1'b0, dv_reg};
                q_reg   <= {q_reg[NUM_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                q_reg   <= {q_reg[NUM_BITS-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;
endmodule

[sv/depth_gradient_hole_fill.sv]
// Top level of the depth gradient hole fill block: stores, pass sequencer, result port.
//
//  channel   | signals                                         | handshake
//  ----------+-------------------------------------------------+---------------------------
//  command   | operation pixel_address depth_in depth_known    | start & !busy
//            | grad_x grad_y                                   |
//  result    | depth_out known_out passes_used hit_limit       | done, one cycle, no stall
//  config    | cfg_we cfg_index cfg_data                       | cfg_we
//
// Write and read transactions pass through the memory read register, then the result register.
// A run first counts the holes in one sweep, then each pass sweeps three times: mark, which reads
// the neighbours of each hole one by one (one read port on the known store); fill, which uses the
// shared divider once per marked pixel; set known, which sets the known flag of each marked pixel.
// After reset the known and mark stores are cleared entry by entry, while busy is high.
// The receiver cannot stall.
module depth_gradient_hole_fill
    import dghf_pkg::*;
#(
    parameter int MAX_PIXELS = 4096,
    parameter int DEPTH_BITS = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              operation,
    input  logic [11:0]             pixel_address,
    input  logic signed [31:0]      depth_in,
    input  logic                    depth_known,
    input  logic signed [31:0]      grad_x,
    input  logic signed [31:0]      grad_y,
    input  logic                    cfg_we,
    input  logic [1:0]              cfg_index,
    input  logic [CFG_BITS-1:0]     cfg_data,
    output logic                    done,
    output logic signed [31:0]      depth_out,
    output logic                    known_out,
    output logic [9:0]              passes_used,
    output logic                    hit_limit
);
`include "depth_gradient_hole_fill_defines.svh"
    localparam int AW  = $clog2(MAX_PIXELS);
    localparam int IW  = AW + 1;
    localparam int SW  = DEPTH_BITS + 4;
    localparam logic signed [SW-1:0] SAT_HI = SW'({1'b0, {(DEPTH_BITS-1){1'b1}}});
    localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_RDWAIT, S_COUNT_RD, S_COUNT_CHK,
        S_PASS, S_MARK_C, S_MARK_N, S_MARK_W,
        S_FILL_RD, S_FILL_NB, S_FILL_NW, S_FILL_ACC, S_FILL_DIV, S_FILL_WR,
        S_SET_RD, S_SET_W, S_FINISH
    } state_t;

    state_t            state_reg;
    logic [6:0]        height_reg, width_reg;
    logic [9:0]        limit_reg;
    logic [9:0]        passes_reg, last_reg;
    logic              flag_reg;
    logic [IW-1:0]     idx_reg, total_reg;
    logic [IW-1:0]     holes_reg, marked_reg;
    logic [6:0]        y_reg, x_reg;
    logic [2:0]        nb_reg;
    logic [3:0]        m_reg;
    logic [2:0]        n_reg;
    logic signed [SW-1:0] sum_reg;
    logic signed [DEPTH_BITS-1:0] gx_reg, gy_reg;
    logic              sign_reg;
    logic              done_reg, kout_reg;
    logic [31:0]       dout_reg;
    logic              rd_read_reg, rd_oob_reg;
    logic              div_start;
    // registered validity of the neighbour whose known flag arrives next cycle
    logic              nb_okp_reg;

    // RAM ports
    logic              d_we, k_we, m_we, g_we;
    logic [AW-1:0]     d_wa, k_wa, m_wa, g_wa;
    logic [AW-1:0]     d_ra, k_ra, m_ra, g_ra;
    logic [DEPTH_BITS-1:0] d_wd, d_rd;
    logic              k_wd, k_rd;
    logic [3:0]        m_wd, m_rd;
    logic [2*DEPTH_BITS-1:0] g_wd, g_rd;
    logic [SW-1:0]     div_q;
    logic              div_done;
    logic [SW-1:0]     div_num;

    logic [6:0]        h_eff, w_eff;
    logic [13:0]       hw;
    logic [IW-1:0]     nb_idx;
    logic              nb_ok;
    logic signed [SW-1:0] dext, gterm, mag_s, rounded;

    assign h_eff = (height_reg == '0) ? 7'd1 : height_reg;
    assign w_eff = (width_reg == '0) ? 7'd1 : width_reg;
    assign hw    = h_eff * w_eff;

    dghf_ram #(.WIDTH(DEPTH_BITS), .DEPTH(MAX_PIXELS)) u_depth (
        .clk(clk), .we(d_we), .waddr(d_wa), .wdata(d_wd), .raddr(d_ra), .rdata(d_rd));
    dghf_ram #(.WIDTH(1), .DEPTH(MAX_PIXELS)) u_known (
        .clk(clk), .we(k_we), .waddr(k_wa), .wdata(k_wd), .raddr(k_ra), .rdata(k_rd));
    dghf_ram #(.WIDTH(4), .DEPTH(MAX_PIXELS)) u_marks (
        .clk(clk), .we(m_we), .waddr(m_wa), .wdata(m_wd), .raddr(m_ra), .rdata(m_rd));
    dghf_ram #(.WIDTH(2*DEPTH_BITS), .DEPTH(MAX_PIXELS)) u_grad (
        .clk(clk), .we(g_we), .waddr(g_wa), .wdata(g_wd), .raddr(g_ra), .rdata(g_rd));

    dghf_div #(.NUM_BITS(SW)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_num),
        .divisor({n_reg, 1'b0}), .done(div_done), .quotient(div_q));

    // neighbour under test during mark / fill: 0 left, 1 right, 2 up, 3 down
    always_comb
    begin
        nb_idx = idx_reg;
        nb_ok  = 1'b0;
        case (nb_reg[1:0])
            2'd0:
            begin
                nb_idx = idx_reg - IW'(h_eff);
                nb_ok  = (x_reg != '0);
            end
            2'd1:
            begin
                nb_idx = idx_reg + IW'(h_eff);
                nb_ok  = (x_reg + 7'd1 < w_eff) && ((idx_reg + IW'(h_eff)) < total_reg);
            end
            2'd2:
            begin
                nb_idx = idx_reg - IW'(1);
                nb_ok  = (y_reg != '0);
            end
            default:
            begin
                nb_idx = idx_reg + IW'(1);
                nb_ok  = (y_reg + 7'd1 < h_eff) && ((idx_reg + IW'(1)) < total_reg);
            end
        endcase
    end

    assign dext  = SW'(signed'(d_rd));
    always_comb
    begin
        case (nb_reg[1:0])
            2'd0:    gterm = SW'(gx_reg);
            2'd1:    gterm = -SW'(gx_reg);
            2'd2:    gterm = SW'(gy_reg);
            default: gterm = -SW'(gy_reg);
        endcase
    end
    assign mag_s   = sum_reg[SW-1] ? -sum_reg : sum_reg;
    assign div_num = mag_s + SW'(n_reg);
    assign rounded = sign_reg ? -signed'(div_q) : signed'(div_q);

    always_comb
    begin
        d_we = 1'b0; d_wa = AW'(pixel_address); d_wd = DEPTH_BITS'(depth_in);
        k_we = 1'b0; k_wa = AW'(pixel_address); k_wd = depth_known;
        m_we = 1'b0; m_wa = idx_reg[AW-1:0];      m_wd = '0;
        g_we = 1'b0; g_wa = AW'(pixel_address);
        g_wd = {DEPTH_BITS'(grad_y), DEPTH_BITS'(grad_x)};
        d_ra = AW'(pixel_address);
        k_ra = AW'(pixel_address);
        m_ra = idx_reg[AW-1:0];
        g_ra = idx_reg[AW-1:0];
        div_start = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                k_we = 1'b1; k_wa = idx_reg[AW-1:0]; k_wd = 1'b0;
                m_we = 1'b1;
            end
            S_IDLE:
            begin
                if (start && operation == OP_WRITE && {20'd0, pixel_address} < 32'(MAX_PIXELS))
                begin
                    d_we = 1'b1; k_we = 1'b1; g_we = 1'b1;
                end
                if (start && operation == OP_RUN)
                begin
                    k_ra = '0;
                end
            end
            S_COUNT_RD, S_COUNT_CHK, S_MARK_C, S_SET_RD:
            begin
                k_ra = idx_reg[AW-1:0];
            end
            S_MARK_N, S_MARK_W:
            begin
                k_ra = nb_idx[AW-1:0];
                if (state_reg == S_MARK_W && nb_reg == 3'd4)
                begin
                    m_we = 1'b1; m_wd = m_reg;
                end
            end
            S_FILL_NB, S_FILL_NW:
            begin
                d_ra = nb_idx[AW-1:0];
            end
            S_FILL_WR:
            begin
                d_we = (m_reg != '0); d_wa = idx_reg[AW-1:0];
                d_wd = (rounded > SAT_HI) ? SAT_HI[DEPTH_BITS-1:0] :
                       (rounded < SAT_LO) ? SAT_LO[DEPTH_BITS-1:0] :
                       rounded[DEPTH_BITS-1:0];
            end
            S_SET_W:
            begin
                k_we = (m_rd != '0); k_wa = idx_reg[AW-1:0]; k_wd = 1'b1;
            end
            default:
            begin
            end
        endcase
        if (state_reg == S_FILL_ACC && nb_reg == 3'd4 && n_reg != '0)
        begin
            div_start = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            height_reg <= 7'd64;
            width_reg  <= 7'd64;
            limit_reg  <= DEFAULT_PASS_LIMIT;
            last_reg   <= '0;
            flag_reg   <= 1'b0;
            idx_reg    <= '0;
            done_reg   <= 1'b0;
            rd_read_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_HEIGHT: height_reg <= cfg_data[6:0];
                    REG_WIDTH:  width_reg  <= cfg_data[6:0];
                    REG_LIMIT:  limit_reg  <= cfg_data[9:0];
                    default:
                    begin
                    end
                endcase
            end
            case (state_reg)
                S_CLEAR:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == IW'(MAX_PIXELS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        rd_read_reg <= (operation == OP_READ);
                        rd_oob_reg  <= ({20'd0, pixel_address} >= 32'(MAX_PIXELS));
                        if (operation == OP_RUN)
                        begin
                            total_reg  <= (32'(hw) > 32'(MAX_PIXELS)) ? IW'(MAX_PIXELS) : IW'(hw);
                            idx_reg    <= '0;
                            holes_reg  <= '0;
                            passes_reg <= '0;
                            state_reg  <= S_COUNT_RD;
                        end
                        else
                        begin
                            state_reg <= S_RDWAIT;
                        end
                    end
                end
                S_RDWAIT:
                begin
                    done_reg  <= 1'b1;
                    kout_reg  <= rd_read_reg && !rd_oob_reg && k_rd;
                    dout_reg  <= (rd_read_reg && !rd_oob_reg && k_rd) ?
                                 32'(signed'(d_rd)) : 32'd0;
                    state_reg <= S_IDLE;
                end
                S_COUNT_RD:
                begin
                    state_reg <= (idx_reg < total_reg) ? S_COUNT_CHK : S_PASS;
                end
                S_COUNT_CHK:
                begin
                    if (!k_rd)
                    begin
                        holes_reg <= holes_reg + 1'b1;
                    end
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= S_COUNT_RD;
                end
                S_PASS:
                begin
                    if (passes_reg >= limit_reg)
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        passes_reg <= passes_reg + 1'b1;
                        if (holes_reg == '0)
                        begin
                            state_reg <= S_FINISH;
                        end
                        else
                        begin
                            idx_reg    <= '0;
                            x_reg      <= '0;
                            y_reg      <= '0;
                            marked_reg <= '0;
                            state_reg  <= S_MARK_C;
                        end
                    end
                end
                S_MARK_C:
                begin
                    // idx read issued this cycle; result next
                    m_reg     <= '0;
                    nb_reg    <= '0;
                    state_reg <= S_MARK_N;
                end
                S_MARK_N:
                begin
                    if (idx_reg >= total_reg)
                    begin
                        state_reg <= (marked_reg == '0) ? S_FINISH : S_FILL_RD;
                        if (marked_reg == '0)
                        begin
                            passes_reg <= limit_reg;
                        end
                        idx_reg <= '0; x_reg <= '0; y_reg <= '0;
                    end
                    else if (k_rd)
                    begin
                        nb_reg    <= 3'd4;
                        state_reg <= S_MARK_W;
                    end
                    else
                    begin
                        state_reg <= S_MARK_W;
                    end
                end
                S_MARK_W:
                begin
                    // k_rd holds the known flag of neighbour nb_reg-1 for nb_reg 1 to 3, and of neighbour 3 at nb_reg 5
                    if (nb_reg == 3'd4)
                    begin
                        if (m_reg != '0)
                        begin
                            marked_reg <= marked_reg + 1'b1;
                        end
                        idx_reg <= idx_reg + 1'b1;
                        if (y_reg + 7'd1 == h_eff)
                        begin
                            y_reg <= '0; x_reg <= x_reg + 1'b1;
                        end
                        else
                        begin
                            y_reg <= y_reg + 1'b1;
                        end
                        state_reg <= S_MARK_C;
                    end
                    else
                    begin
                        nb_reg <= nb_reg + 1'b1;
                        state_reg <= S_MARK_W;
                    end
                    if (nb_reg != 3'd0 && nb_reg != 3'd4 && k_rd && nb_okp_reg)
                    begin
                        m_reg <= m_reg | (4'b0001 << (nb_reg[1:0] - 2'd1));
                    end
                    if (nb_reg == 3'd3)
                    begin
                        nb_reg <= 3'd5;
                    end
                    if (nb_reg == 3'd5)
                    begin
                        if (k_rd && nb_okp_reg)
                        begin
                            m_reg <= m_reg | M_DOWN;
                        end
                        nb_reg <= 3'd4;
                    end
                end
                S_FILL_RD:
                begin
                    if (idx_reg >= total_reg)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_SET_RD;
                    end
                    else
                    begin
                        state_reg <= S_FILL_NB;
                    end
                end
                S_FILL_NB:
                begin
                    // marks and gradients of idx now valid
                    m_reg   <= m_rd;
                    gx_reg  <= g_rd[DEPTH_BITS-1:0];
                    gy_reg  <= g_rd[2*DEPTH_BITS-1:DEPTH_BITS];
                    sum_reg <= '0;
                    n_reg   <= '0;
                    nb_reg  <= '0;
                    state_reg <= (m_rd == '0) ? S_FILL_WR : S_FILL_NW;
                end
                S_FILL_NW:
                begin
                    state_reg <= S_FILL_ACC;
                end
                S_FILL_ACC:
                begin
                    if (nb_reg == 3'd4)
                    begin
                        sign_reg  <= sum_reg[SW-1];
                        state_reg <= S_FILL_DIV;
                    end
                    else
                    begin
                        if (m_reg[nb_reg[1:0]])
                        begin
                            sum_reg <= sum_reg + (dext <<< 1) + gterm;
                            n_reg   <= n_reg + 1'b1;
                        end
                        nb_reg    <= nb_reg + 1'b1;
                        state_reg <= (nb_reg == 3'd3) ? S_FILL_ACC : S_FILL_NW;
                    end
                end
                S_FILL_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_FILL_WR;
                    end
                end
                S_FILL_WR:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (y_reg + 7'd1 == h_eff)
                    begin
                        y_reg <= '0; x_reg <= x_reg + 1'b1;
                    end
                    else
                    begin
                        y_reg <= y_reg + 1'b1;
                    end
                    state_reg <= S_FILL_RD;
                end
                S_SET_RD:
                begin
                    state_reg <= (idx_reg < total_reg) ? S_SET_W : S_PASS;
                    if (idx_reg >= total_reg)
                    begin
                        holes_reg <= holes_reg - marked_reg;
                    end
                end
                S_SET_W:
                begin
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= S_SET_RD;
                end
                S_FINISH:
                begin
                    last_reg  <= passes_reg;
                    flag_reg  <= (holes_reg != '0);
                    done_reg  <= 1'b1;
                    kout_reg  <= 1'b0;
                    dout_reg  <= '0;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        nb_okp_reg <= nb_ok;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign depth_out   = dout_reg;
    assign known_out   = kout_reg;
    assign passes_used = (state_reg == S_IDLE && !done_reg) ? last_reg : last_reg;
    assign hit_limit   = flag_reg;

    `DGHF_ASSERT_NEXT(a_busy_after_start, clk, rst_n, start && !busy, busy)
    `DGHF_ASSERT_IMPL(a_done_idle, clk, rst_n, done, state_reg == S_IDLE)
    `DGHF_ASSERT_IMPL(a_known_zero_dout, clk, rst_n, done && !known_out, depth_out == '0)
endmodule
